[hw/rtl/itng_pkg.sv]
// shared constants, codes and types of the input trim and noise gate
package itng_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int COEFF_BITS   = 16;
  localparam int RAMP_BITS    = 16;
  localparam int GAIN_FRAC    = SAMPLE_BITS - 4;
  localparam int THR_BITS     = SAMPLE_BITS - 1;
  localparam int MUL_BITS     = SAMPLE_BITS + 1;
  localparam int PROD_BITS    = 2 * MUL_BITS;
  localparam int ENV_SUM_BITS = THR_BITS + COEFF_BITS + 2;
  localparam int DIV_CNT_BITS = $clog2(SAMPLE_BITS + 1);
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = SAMPLE_BITS;

  localparam logic [SAMPLE_BITS-1:0] GAIN_RESET    = SAMPLE_BITS'(1) << GAIN_FRAC;
  localparam logic [THR_BITS-1:0]    THR_RESET     = THR_BITS'(83886);
  localparam logic [COEFF_BITS-1:0]  ATTACK_RESET  = COEFF_BITS'(64184);
  localparam logic [COEFF_BITS-1:0]  RELEASE_RESET = COEFF_BITS'(65522);
  localparam logic [RAMP_BITS-1:0]   RAMP_RESET    = RAMP_BITS'(960);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TRIM_GAIN      = 3'd0,
    REG_GATE_THRESHOLD = 3'd1,
    REG_GATE_ENABLE    = 3'd2,
    REG_ATTACK_COEFF   = 3'd3,
    REG_RELEASE_COEFF  = 3'd4,
    REG_RAMP_STEPS     = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MULG,
    S_SAT,
    S_MULE,
    S_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic mul_env;
    logic sat_en;
    logic fin_en;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_full;
  } status_t;

endpackage

[hw/rtl/itng_div.sv]
// restoring divider, one quotient bit per cycle, quotient truncated toward zero
module itng_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [itng_pkg::SAMPLE_BITS-1:0]     num_i,
  input  logic [itng_pkg::RAMP_BITS-1:0]       den_i,
  input  logic                                 neg_i,
  output logic                                 busy_o,
  output logic signed [itng_pkg::SAMPLE_BITS:0] quot_o
);

  logic [itng_pkg::SAMPLE_BITS-1:0]  acc_q;
  logic [itng_pkg::RAMP_BITS-1:0]    rem_q;
  logic [itng_pkg::RAMP_BITS-1:0]    den_q;
  logic                              neg_q;
  logic [itng_pkg::DIV_CNT_BITS-1:0] cnt_q;
  logic [itng_pkg::RAMP_BITS:0]      shifted;
  logic [itng_pkg::RAMP_BITS:0]      trial;
  logic signed [itng_pkg::SAMPLE_BITS:0] mag;

  assign shifted = {rem_q, acc_q[itng_pkg::SAMPLE_BITS-1]};
  assign trial   = shifted - {1'b0, den_q};
  assign busy_o  = (cnt_q != '0);
  assign mag     = $signed({1'b0, acc_q});
  assign quot_o  = neg_q ? -mag : mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= itng_pkg::DIV_CNT_BITS'(itng_pkg::SAMPLE_BITS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= neg_i;
    end else if (cnt_q != '0) begin
      acc_q <= {acc_q[itng_pkg::SAMPLE_BITS-2:0], ~trial[itng_pkg::RAMP_BITS]};
      rem_q <= trial[itng_pkg::RAMP_BITS] ? shifted[itng_pkg::RAMP_BITS-1:0]
                                          : trial[itng_pkg::RAMP_BITS-1:0];
    end
  end

endmodule

[hw/rtl/itng_ctrl.sv]
// sequencer for one item: gain multiply, saturate, envelope multiply, finish
module itng_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  itng_pkg::status_t status_i,
  output itng_pkg::cmd_t    cmd_o
);

  itng_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itng_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      itng_pkg::S_IDLE: begin
        if (in_valid_i && !status_i.div_busy) state_d = itng_pkg::S_MULG;
      end
      itng_pkg::S_MULG: state_d = itng_pkg::S_SAT;
      itng_pkg::S_SAT:  state_d = itng_pkg::S_MULE;
      itng_pkg::S_MULE: state_d = itng_pkg::S_FIN;
      itng_pkg::S_FIN: begin
        if (!status_i.out_full) state_d = itng_pkg::S_IDLE;
      end
      default: state_d = itng_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      itng_pkg::S_IDLE: begin
        in_ready_o = !status_i.div_busy;
        cmd_o.load = in_valid_i && !status_i.div_busy;
      end
      itng_pkg::S_MULG: cmd_o.mul_en = 1'b1;
      itng_pkg::S_SAT:  cmd_o.sat_en = 1'b1;
      itng_pkg::S_MULE: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_env = 1'b1;
      end
      itng_pkg::S_FIN:  cmd_o.fin_en = !status_i.out_full;
      default: ;
    endcase
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == itng_pkg::S_MULG)
    else $error("accepted item did not start the gain multiply");

  a_fin_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == itng_pkg::S_FIN && !status_i.out_full |=> state_q == itng_pkg::S_IDLE)
    else $error("finish step did not return to idle");

  a_no_accept_while_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_busy |-> !in_ready_o)
    else $error("item taken while a ramp increment is still being divided");

endmodule

[hw/rtl/itng_dp.sv]
// datapath: settings, ramps, shared multiplier, envelope follower, output register
module itng_dp (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [itng_pkg::CFG_IDX_BITS-1:0]       cfg_addr_i,
  input  logic [itng_pkg::CFG_DATA_BITS-1:0]      cfg_data_i,
  input  logic signed [itng_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic                                    out_ready_i,
  input  itng_pkg::cmd_t                          cmd_i,
  output itng_pkg::status_t                       status_o,
  output logic                                    out_valid_o,
  output logic signed [itng_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic                                    gate_open_o
);

  localparam int SB = itng_pkg::SAMPLE_BITS;
  localparam int TB = itng_pkg::THR_BITS;
  localparam int CB = itng_pkg::COEFF_BITS;
  localparam int RB = itng_pkg::RAMP_BITS;
  localparam int MB = itng_pkg::MUL_BITS;
  localparam int PB = itng_pkg::PROD_BITS;
  localparam int EB = itng_pkg::ENV_SUM_BITS;
  localparam int GF = itng_pkg::GAIN_FRAC;

  // settings
  logic [SB-1:0] trim_gain_q;
  logic [TB-1:0] gate_thr_q;
  logic          gate_en_q;
  logic [CB-1:0] attack_q;
  logic [CB-1:0] release_q;
  logic [RB-1:0] ramp_steps_q;

  // ramp state
  logic [SB-1:0] gain_now_q, gain_now_d;
  logic [RB-1:0] gain_left_q, gain_left_d;
  logic [TB-1:0] thr_now_q, thr_now_d;
  logic [RB-1:0] thr_left_q, thr_left_d;
  logic [TB-1:0] env_q;

  // item pipeline
  logic signed [SB-1:0] sample_q;
  logic signed [PB-1:0] prod_q;
  logic signed [SB-1:0] y_q;
  logic [TB-1:0]        level_q;
  logic signed [SB-1:0] diff_q;
  logic [CB-1:0]        coef_q;
  logic                 out_valid_q;
  logic signed [SB-1:0] out_sample_q;
  logic                 out_open_q;

  // dividers
  logic                 gdiv_start, tdiv_start, gdiv_busy, tdiv_busy;
  logic [SB-1:0]        gdiv_num, tdiv_num;
  logic                 gdiv_neg, tdiv_neg;
  logic signed [SB:0]   gain_inc, thr_quot;
  logic signed [TB:0]   thr_inc;

  logic                 gain_wr, thr_wr;
  logic signed [SB+1:0] gdiff, tdiff, gsum, tsum;
  logic signed [SB+1:0] gdiff_abs, tdiff_abs;

  logic signed [MB-1:0] mul_a, mul_b;
  logic signed [PB-1:0] rnd, rsh;
  logic signed [SB-1:0] y_sat, y_abs;
  logic [TB-1:0]        level;
  logic signed [EB-1:0] env_sum;
  logic [TB-1:0]        env_new;
  logic                 open_new;

  // target writes and divider starts
  assign gain_wr = cfg_we_i && (cfg_addr_i == itng_pkg::REG_TRIM_GAIN)
                   && (cfg_data_i != trim_gain_q);
  assign thr_wr  = cfg_we_i && (cfg_addr_i == itng_pkg::REG_GATE_THRESHOLD)
                   && (cfg_data_i[TB-1:0] != gate_thr_q);

  assign gdiff     = $signed({2'b00, cfg_data_i}) - $signed({2'b00, gain_now_q});
  assign tdiff     = $signed({3'b000, cfg_data_i[TB-1:0]}) - $signed({3'b000, thr_now_q});
  assign gdiff_abs = gdiff[SB+1] ? -gdiff : gdiff;
  assign tdiff_abs = tdiff[SB+1] ? -tdiff : tdiff;
  assign gdiv_num  = gdiff_abs[SB-1:0];
  assign tdiv_num  = tdiff_abs[SB-1:0];
  assign gdiv_neg  = gdiff[SB+1];
  assign tdiv_neg  = tdiff[SB+1];
  assign gdiv_start = gain_wr && (ramp_steps_q != '0);
  assign tdiv_start = thr_wr && (ramp_steps_q != '0);
  assign thr_inc   = thr_quot[TB:0];

  itng_div u_gain_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (gdiv_start),
    .num_i   (gdiv_num),
    .den_i   (ramp_steps_q),
    .neg_i   (gdiv_neg),
    .busy_o  (gdiv_busy),
    .quot_o  (gain_inc)
  );

  itng_div u_thr_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tdiv_start),
    .num_i   (tdiv_num),
    .den_i   (ramp_steps_q),
    .neg_i   (tdiv_neg),
    .busy_o  (tdiv_busy),
    .quot_o  (thr_quot)
  );

  // settings registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_gain_q  <= itng_pkg::GAIN_RESET;
      gate_thr_q   <= itng_pkg::THR_RESET;
      gate_en_q    <= 1'b0;
      attack_q     <= itng_pkg::ATTACK_RESET;
      release_q    <= itng_pkg::RELEASE_RESET;
      ramp_steps_q <= itng_pkg::RAMP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        itng_pkg::REG_TRIM_GAIN:      trim_gain_q  <= cfg_data_i;
        itng_pkg::REG_GATE_THRESHOLD: gate_thr_q   <= cfg_data_i[TB-1:0];
        itng_pkg::REG_GATE_ENABLE:    gate_en_q    <= cfg_data_i[0];
        itng_pkg::REG_ATTACK_COEFF:   attack_q     <= cfg_data_i[CB-1:0];
        itng_pkg::REG_RELEASE_COEFF:  release_q    <= cfg_data_i[CB-1:0];
        itng_pkg::REG_RAMP_STEPS:     ramp_steps_q <= cfg_data_i[RB-1:0];
        default: ;
      endcase
    end
  end

  // gain ramp: steps once per accepted item, before the multiply
  assign gsum = $signed({2'b00, gain_now_q}) + (SB + 2)'(gain_inc);

  always_comb begin
    gain_now_d  = gain_now_q;
    gain_left_d = gain_left_q;
    if (gain_wr) begin
      if (ramp_steps_q == '0) begin
        gain_now_d  = cfg_data_i;
        gain_left_d = '0;
      end else begin
        gain_left_d = ramp_steps_q;
      end
    end else if (cmd_i.load && (gain_left_q != '0)) begin
      gain_left_d = gain_left_q - 1'b1;
      gain_now_d  = (gain_left_q == RB'(1)) ? trim_gain_q : gsum[SB-1:0];
    end
  end

  // threshold ramp: steps only on items seen while the gate is enabled
  assign tsum = $signed({3'b000, thr_now_q}) + (SB + 2)'(thr_inc);

  always_comb begin
    thr_now_d  = thr_now_q;
    thr_left_d = thr_left_q;
    if (thr_wr) begin
      if (ramp_steps_q == '0) begin
        thr_now_d  = cfg_data_i[TB-1:0];
        thr_left_d = '0;
      end else begin
        thr_left_d = ramp_steps_q;
      end
    end else if (cmd_i.sat_en && gate_en_q && (thr_left_q != '0)) begin
      thr_left_d = thr_left_q - 1'b1;
      thr_now_d  = (thr_left_q == RB'(1)) ? gate_thr_q : tsum[TB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_now_q  <= itng_pkg::GAIN_RESET;
      gain_left_q <= '0;
      thr_now_q   <= itng_pkg::THR_RESET;
      thr_left_q  <= '0;
      env_q       <= '0;
    end else begin
      gain_now_q  <= gain_now_d;
      gain_left_q <= gain_left_d;
      thr_now_q   <= thr_now_d;
      thr_left_q  <= thr_left_d;
      if (cmd_i.fin_en && gate_en_q) begin
        env_q <= env_new;
      end
    end
  end

  // shared multiplier: sample times gain, then coefficient times envelope step
  assign mul_a = cmd_i.mul_env ? MB'(diff_q) : MB'(sample_q);
  assign mul_b = cmd_i.mul_env ? $signed(MB'(coef_q)) : $signed({1'b0, gain_now_q});

  // round to nearest, ties up, then saturate
  assign rnd = prod_q + (PB'(1) <<< (GF - 1));
  assign rsh = rnd >>> GF;

  always_comb begin
    if (rsh[PB-1:SB-1] == '0 || rsh[PB-1:SB-1] == '1) begin
      y_sat = rsh[SB-1:0];
    end else if (rsh[PB-1]) begin
      y_sat = {1'b1, {(SB-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(SB-1){1'b1}}};
    end
  end

  assign y_abs = y_sat[SB-1] ? -y_sat : y_sat;
  assign level = y_abs[SB-1] ? {TB{1'b1}} : y_abs[TB-1:0];

  // env_new = level + c * (env - level), rounded
  assign env_sum  = $signed({2'b00, level_q, {CB{1'b0}}}) + EB'(prod_q)
                    + $signed(EB'(1) << (CB - 1));
  assign env_new  = env_sum[CB +: TB];
  assign open_new = !gate_en_q || (env_new > thr_now_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_in_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.sat_en) begin
      y_q     <= y_sat;
      level_q <= level;
      diff_q  <= $signed({1'b0, env_q}) - $signed({1'b0, level});
      coef_q  <= (level > env_q) ? attack_q : release_q;
    end
    if (cmd_i.fin_en) begin
      out_sample_q <= open_new ? y_q : '0;
      out_open_q   <= open_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.div_busy = gdiv_busy || tdiv_busy;
  assign status_o.out_full = out_valid_q && !out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign sample_out_o      = out_sample_q;
  assign gate_open_o       = out_open_q;

  a_muted_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !gate_open_o |-> sample_out_o == '0)
    else $error("muted item carries a nonzero sample");

  a_bypass_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fin_en && !gate_en_q |=> gate_open_o)
    else $error("gate closed while disabled");

  a_gain_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i && gain_left_q == '0 |=> $stable(gain_now_q))
    else $error("gain moved with no ramp running");

endmodule

[hw/rtl/input_trim_noise_gate.sv]
// input trim with ramped gain, envelope follower and noise gate: top level
// a result passes through the gain multiply, saturate, envelope multiply and finish steps before it is shown
// a new item is taken only once the sequencer is back in idle after the last one, since the multiplier is shared
// a trim or threshold write that starts a ramp holds off items while the increment divider is busy
// reset: asynchronous active-low; settings and ramps return to defaults, envelope to zero
// configuration writes are taken on any cycle with no wait
module input_trim_noise_gate (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [itng_pkg::CFG_IDX_BITS-1:0]           cfg_addr_i,
  input  logic [itng_pkg::CFG_DATA_BITS-1:0]          cfg_data_i,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic signed [itng_pkg::SAMPLE_BITS-1:0]     sample_in_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic signed [itng_pkg::SAMPLE_BITS-1:0]     sample_out_o,
  output logic                                        gate_open_o
);

  itng_pkg::cmd_t    cmd;
  itng_pkg::status_t status;

  itng_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  itng_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .sample_in_i  (sample_in_i),
    .out_ready_i  (out_ready_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .sample_out_o (sample_out_o),
    .gate_open_o  (gate_open_o)
  );

endmodule

[test/input_trim_noise_gate_test.sv]
// testbench for the input trim and noise gate, checked against its own gate predictor
module input_trim_noise_gate_test;
  import itng_pkg::*;

  localparam longint SMAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam longint COEFF_ONE = longint'(1) << COEFF_BITS;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_7 = 3'd7;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          open;
  } gated_sample_t;

  typedef struct {
    bit                            is_cfg;
    logic [CFG_IDX_BITS-1:0]       addr;
    logic [CFG_DATA_BITS-1:0]      data;
    logic signed [SAMPLE_BITS-1:0] smp;
    bit                            typed;
    gated_sample_t                 want;
  } plan_row_t;

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]       cfg_addr_i = REG_TRIM_GAIN;
  logic [CFG_DATA_BITS-1:0]      cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic signed [SAMPLE_BITS-1:0] sample_in_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out_o;
  logic                          gate_open_o;

  input_trim_noise_gate u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .gate_open_o  (gate_open_o)
  );

  // predictor state and settings
  longint tgt_gain, tgt_thr, gate_on, atk_c, rel_c, ramp_len;
  longint gain_cur, gain_step, gain_left;
  longint thr_cur, thr_step, thr_left;
  longint env_level;

  gated_sample_t expected_gated[$];
  plan_row_t     directed_plan[$];

  int  send_pct = 0;
  int  recv_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  bit  cfg_busy = 1'b0;
  int  mismatches = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  muted_seen = 0;
  int  writes_done = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("input_trim_noise_gate_test NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < 20) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    end
    mismatches++;
  endtask

  function automatic void reset_model();
    tgt_gain  = GAIN_RESET;
    tgt_thr   = THR_RESET;
    gate_on   = 0;
    atk_c     = ATTACK_RESET;
    rel_c     = RELEASE_RESET;
    ramp_len  = RAMP_RESET;
    gain_cur  = GAIN_RESET;
    gain_step = 0;
    gain_left = 0;
    thr_cur   = THR_RESET;
    thr_step  = 0;
    thr_left  = 0;
    env_level = 0;
  endfunction

  function automatic void begin_ramp(input longint tgt, inout longint cur, output longint step,
                                     output longint left);
    if (ramp_len == 0) begin
      cur  = tgt;
      step = 0;
      left = 0;
    end else begin
      step = (tgt - cur) / ramp_len;
      left = ramp_len;
    end
  endfunction

  function automatic void advance_ramp(input longint tgt, inout longint cur, input longint step,
                                       inout longint left);
    if (left != 0) begin
      left = left - 1;
      if (left != 0) begin
        cur = cur + step;
      end else begin
        cur = tgt;
      end
    end
  endfunction

  function automatic void apply_setting(input logic [CFG_IDX_BITS-1:0] idx,
                                        input logic [CFG_DATA_BITS-1:0] data);
    longint v;
    case (idx)
      REG_TRIM_GAIN: begin
        v = longint'(data);
        if (v != tgt_gain) begin
          tgt_gain = v;
          begin_ramp(v, gain_cur, gain_step, gain_left);
        end
      end
      REG_GATE_THRESHOLD: begin
        v = longint'(data[THR_BITS-1:0]);
        if (v != tgt_thr) begin
          tgt_thr = v;
          begin_ramp(v, thr_cur, thr_step, thr_left);
        end
      end
      REG_GATE_ENABLE:   gate_on = longint'(data[0]);
      REG_ATTACK_COEFF:  atk_c = longint'(data[COEFF_BITS-1:0]);
      REG_RELEASE_COEFF: rel_c = longint'(data[COEFF_BITS-1:0]);
      REG_RAMP_STEPS:    ramp_len = longint'(data[RAMP_BITS-1:0]);
      default: ;
    endcase
  endfunction

  function automatic gated_sample_t predict_gate(input logic signed [SAMPLE_BITS-1:0] smp);
    longint x, y, lvl, c;
    gated_sample_t r;
    x = smp;
    advance_ramp(tgt_gain, gain_cur, gain_step, gain_left);
    y = (x * gain_cur + (longint'(1) << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
    if (y > SMAX) y = SMAX;
    if (y < SMIN) y = SMIN;
    r.open = 1'b1;
    if (gate_on != 0) begin
      advance_ramp(tgt_thr, thr_cur, thr_step, thr_left);
      lvl = (y < 0) ? -y : y;
      if (lvl > SMAX) lvl = SMAX;
      c = (lvl > env_level) ? atk_c : rel_c;
      env_level = (c * env_level + (COEFF_ONE - c) * lvl + (COEFF_ONE >> 1)) >>> COEFF_BITS;
      if (!(env_level > thr_cur)) begin
        y = 0;
        r.open = 1'b0;
      end
    end
    r.sample = y[SAMPLE_BITS-1:0];
    return r;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] pick_setting(input logic [CFG_IDX_BITS-1:0] idx);
    int sel;
    logic [CFG_DATA_BITS-1:0] v;
    sel = $urandom_range(7);
    v = CFG_DATA_BITS'($urandom());
    case (idx)
      REG_TRIM_GAIN: begin
        if (sel == 0) v = '0;
        else if (sel == 1) v = '1;
        else if (sel <= 3) v = CFG_DATA_BITS'($urandom_range(0, 1 << 21));
        else if (sel == 4) v = GAIN_RESET;
      end
      REG_GATE_THRESHOLD: begin
        if (sel == 0) v = '0;
        else if (sel == 1) v = '1;
        else if (sel <= 4) v = CFG_DATA_BITS'($urandom_range(0, 1 << 16));
      end
      REG_ATTACK_COEFF, REG_RELEASE_COEFF: begin
        if (sel == 0) v = '0;
        else if (sel == 1) v = 24'h00FFFF;
        else if (sel <= 3) v = CFG_DATA_BITS'($urandom_range(60000, 65535));
      end
      REG_RAMP_STEPS: begin
        if (sel == 0) v = '0;
        else if (sel == 1) v = 24'h00FFFF;
        else if (sel == 2) v = CFG_DATA_BITS'($urandom_range(100, 2000));
        else v = CFG_DATA_BITS'($urandom_range(1, 24));
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    int sel;
    logic signed [SAMPLE_BITS-1:0] s;
    sel = $urandom_range(7);
    s = SAMPLE_BITS'($urandom());
    if (sel == 0) s = SMAX[SAMPLE_BITS-1:0];
    else if (sel == 1) s = SMIN[SAMPLE_BITS-1:0];
    else if (sel <= 3) begin
      s = SAMPLE_BITS'($urandom_range(0, 1 << 14));
      if ($urandom_range(1) == 1) s = -s;
    end else if (sel == 4) s = '0;
    return s;
  endfunction

  function automatic void add_setting(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] data);
    plan_row_t row;
    row = '{is_cfg: 1'b1, addr: idx, data: data, smp: '0, typed: 1'b0, want: '0};
    directed_plan.push_back(row);
  endfunction

  function automatic void add_item(input logic signed [SAMPLE_BITS-1:0] smp);
    plan_row_t row;
    row = '{is_cfg: 1'b0, addr: '0, data: '0, smp: smp, typed: 1'b0, want: '0};
    directed_plan.push_back(row);
  endfunction

  function automatic void add_known(input logic signed [SAMPLE_BITS-1:0] smp,
                                    input logic signed [SAMPLE_BITS-1:0] want_smp,
                                    input logic want_open);
    plan_row_t row;
    row = '{is_cfg: 1'b0, addr: '0, data: '0, smp: smp, typed: 1'b1,
            want: '{sample: want_smp, open: want_open}};
    directed_plan.push_back(row);
  endfunction

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_gated.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_setting(input logic [CFG_IDX_BITS-1:0] idx,
                               input logic [CFG_DATA_BITS-1:0] data);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= data;
    cfg_busy = 1'b1;
    apply_setting(idx, data);
    writes_done++;
    @(posedge clk_i);
  endtask

  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] smp, input bit typed,
                             input gated_sample_t known);
    gated_sample_t guess;
    if (cfg_busy) begin
      cfg_we_i <= 1'b0;
      cfg_busy = 1'b0;
    end
    while ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= smp;
    guess = predict_gate(smp);
    expected_gated.push_back(typed ? known : guess);
    items_sent++;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    gated_sample_t want;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (!gate_open_o) muted_seen++;
      if (expected_gated.size() == 0) begin
        report_mismatch("result with none expected, sample_out", sample_out_o, 0);
      end else begin
        want = expected_gated.pop_front();
        if (sample_out_o !== want.sample) begin
          report_mismatch("sample_out", sample_out_o, want.sample);
        end
        if (gate_open_o !== want.open) begin
          report_mismatch("gate_open", gate_open_o, want.open);
        end
      end
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_pct);
    end
  end

  initial begin
    int n;
    logic [CFG_IDX_BITS-1:0] idx;
    reset_model();

    add_known(24'h7FFFFF, 24'h7FFFFF, 1'b1);
    add_known(24'h800000, 24'h800000, 1'b1);
    add_known(24'h000000, 24'h000000, 1'b1);
    add_known(24'hFFFFFF, 24'hFFFFFF, 1'b1);
    add_known(24'h000001, 24'h000001, 1'b1);
    add_setting(REG_SPARE_6, 24'h000000);
    add_setting(REG_SPARE_7, 24'hFFFFFF);
    add_known(24'sd12345, 24'sd12345, 1'b1);
    add_setting(REG_RAMP_STEPS, 24'd0);
    add_setting(REG_TRIM_GAIN, 24'hFFFFFF);
    add_known(24'h7FFFFF, 24'h7FFFFF, 1'b1);
    add_known(24'h800000, 24'h800000, 1'b1);
    add_item(24'sd1);
    add_setting(REG_TRIM_GAIN, 24'd0);
    add_known(24'h7FFFFF, 24'h000000, 1'b1);
    add_setting(REG_RAMP_STEPS, 24'd4);
    add_setting(REG_TRIM_GAIN, 24'd0);
    add_setting(REG_TRIM_GAIN, GAIN_RESET);
    repeat (4) add_item(24'sd1000000);
    add_setting(REG_RAMP_STEPS, 24'd8);
    add_setting(REG_TRIM_GAIN, 24'd2097152);
    add_item(-24'sd777777);
    add_setting(REG_RAMP_STEPS, 24'd2);
    add_item(24'sd3000000);
    add_item(-24'sd5);
    add_setting(REG_RAMP_STEPS, 24'd0);
    add_setting(REG_TRIM_GAIN, GAIN_RESET);
    add_setting(REG_GATE_THRESHOLD, 24'hFFFFFF);
    add_setting(REG_GATE_ENABLE, 24'h000003);
    add_known(24'h7FFFFF, 24'h000000, 1'b0);
    add_setting(REG_ATTACK_COEFF, 24'd0);
    add_setting(REG_RELEASE_COEFF, 24'd0);
    add_setting(REG_GATE_THRESHOLD, 24'd100);
    add_item(24'sd101);
    add_item(-24'sd100);
    add_item(24'sd100);
    add_setting(REG_ATTACK_COEFF, 24'hFFFFFF);
    add_setting(REG_RELEASE_COEFF, 24'h00FFFF);
    add_item(24'h800000);
    add_item(24'sd50);
    add_setting(REG_GATE_ENABLE, 24'hFFFFFE);
    add_known(-24'sd5, -24'sd5, 1'b1);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[k]) begin
      if (directed_plan[k].is_cfg) begin
        write_setting(directed_plan[k].addr, directed_plan[k].data);
      end else begin
        push_sample(directed_plan[k].smp, directed_plan[k].typed, directed_plan[k].want);
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        idx = CFG_IDX_BITS'($urandom_range(7));
        write_setting(idx, pick_setting(idx));
      end
      case (ph % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 81; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 81; end
        default: begin send_pct = 31; recv_pct = 31; end
      endcase
      if (ph == 4) hold_req = 1'b1;
      repeat (70) push_sample(pick_sample(), 1'b0, '0);
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("sent %0d samples through %0d register writes, a directed table and 12 random phases",
             items_sent, writes_done);
    $display("checked %0d results, %0d of them muted by the gate, %0d mismatches", results_seen,
             muted_seen, mismatches);
    if (mismatches == 0) begin
      $display("input_trim_noise_gate_test OK");
    end else begin
      $display("input_trim_noise_gate_test NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/itng_pkg.sv
hw/rtl/itng_div.sv
hw/rtl/itng_ctrl.sv
hw/rtl/itng_dp.sv
hw/rtl/input_trim_noise_gate.sv
test/input_trim_noise_gate_test.sv
